[rtl/hbns_pkg.sv]
// Shared types, constants and helper functions for the hashed block node selector.
`timescale 1ns / 1ps

package hbns_pkg;

  localparam int unsigned NODE_TOTAL      = 5;
  localparam int unsigned MASK_COUNT      = 10;
  localparam int unsigned REPLICA_REGIONS = 3;

  // Pipeline depth up to and including the output register.
  localparam int unsigned PIPE_STAGES = 7;

  localparam logic [63:0] MIX64_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX64_C2     = 64'h94d049bb133111eb;
  localparam logic [31:0] MIX32_K      = 32'h045d9f3b;
  // floor(x / 10) == (x * RECIP10) >> 35 for every 32-bit x
  localparam logic [31:0] RECIP10      = 32'hcccccccd;
  localparam int unsigned RECIP10_SHIFT = 35;
  // (2^64 - 1) / REPLICA_REGIONS and twice that
  localparam logic [63:0] REGION_SPAN  = 64'h5555555555555555;
  localparam logic [63:0] REGION_SPAN2 = 64'haaaaaaaaaaaaaaaa;

  localparam logic [2:0] NODE_COUNT_NONE = 3'd0;
  localparam logic [2:0] NODE_COUNT_ONE  = 3'd1;
  localparam logic [2:0] NODE_COUNT_FULL = 3'(NODE_TOTAL);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_NODE_ADDRESS = 1'b0,
    CFG_NODE_COUNT   = 1'b1
  } cfg_index_t;

  // Per-stage advance strobes, stage 1 at bit 0.
  typedef logic [PIPE_STAGES-1:0] stage_en_t;

  // Early decision made at entry; hashed items resolve at the output stage.
  typedef struct packed {
    logic    use_hash;
    status_t status;
  } pre_dec_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } pick_t;

  function automatic logic [4:0] mask_lookup(input logic [3:0] sel);
    logic [4:0] m;
    case (sel)
      4'd0:    m = 5'd7;
      4'd1:    m = 5'd11;
      4'd2:    m = 5'd13;
      4'd3:    m = 5'd14;
      4'd4:    m = 5'd19;
      4'd5:    m = 5'd21;
      4'd6:    m = 5'd22;
      4'd7:    m = 5'd25;
      4'd8:    m = 5'd26;
      4'd9:    m = 5'd28;
      default: m = 5'd0;
    endcase
    return m;
  endfunction

  // Position of the region-th set bit of mask, counted from bit 0.
  function automatic pick_t pick_set_bit(input logic [4:0] mask, input logic [1:0] region);
    pick_t      p;
    logic [2:0] seen;
    p.found = 1'b0;
    p.idx   = 3'd0;
    seen    = 3'd0;
    for (int i = 0; i < NODE_TOTAL; i++) begin
      if (mask[i] && !p.found) begin
        if (seen == {1'b0, region}) begin
          p.found = 1'b1;
          p.idx   = 3'(i);
        end
        seen = seen + 3'd1;
      end
    end
    return p;
  endfunction

endpackage

[rtl/hbns_mul64.sv]
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 partial products.
`timescale 1ns / 1ps

module hbns_mul64 (
  input  logic        clk,
  input  logic        en_pp,
  input  logic        en_sum,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] pll_r;
  logic [31:0] plh_r;
  logic [31:0] phl_r;
  logic [63:0] p_r;

  logic [63:0] pll_nxt;
  logic [31:0] plh_nxt;
  logic [31:0] phl_nxt;
  logic [63:0] p_nxt;

  // cross terms only matter in their low 32 bits
  assign pll_nxt = a[31:0] * b[31:0];
  assign plh_nxt = a[31:0] * b[63:32];
  assign phl_nxt = a[63:32] * b[31:0];
  assign p_nxt   = pll_r + {plh_r + phl_r, 32'd0};

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pll_r <= pll_nxt;
      plh_r <= plh_nxt;
      phl_r <= phl_nxt;
    end
    if (en_sum) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

[rtl/hbns_mix64.sv]
// splitmix64 finalizer over the key and reduction of the hash to a replica region.
`timescale 1ns / 1ps

module hbns_mix64 (
  input  logic                clk,
  input  hbns_pkg::stage_en_t en,
  input  logic [63:0]         key,
  output logic [1:0]          region
);

  logic [63:0] x1_r;
  logic [63:0] x1_nxt;
  logic [63:0] pa;
  logic [63:0] pb;
  logic [63:0] xa;
  logic [63:0] h;
  logic [1:0]  region_r;
  logic [1:0]  region_nxt;

  assign x1_nxt = key ^ (key >> 30);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r <= x1_nxt;
    end
  end

  hbns_mul64 u_mul_a (
    .clk    (clk),
    .en_pp  (en[1]),
    .en_sum (en[2]),
    .a      (x1_r),
    .b      (hbns_pkg::MIX64_C1),
    .p      (pa)
  );

  assign xa = pa ^ (pa >> 27);

  hbns_mul64 u_mul_b (
    .clk    (clk),
    .en_pp  (en[3]),
    .en_sum (en[4]),
    .a      (xa),
    .b      (hbns_pkg::MIX64_C2),
    .p      (pb)
  );

  assign h = pb ^ (pb >> 31);

  // quotient by the region span: only all-ones lands in region 3
  always_comb begin
    if (h < hbns_pkg::REGION_SPAN) begin
      region_nxt = 2'd0;
    end else if (h < hbns_pkg::REGION_SPAN2) begin
      region_nxt = 2'd1;
    end else if (h != '1) begin
      region_nxt = 2'd2;
    end else begin
      region_nxt = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      region_r <= region_nxt;
    end
  end

  assign region = region_r;

endmodule

[rtl/hbns_mask_sel.sv]
// 32-bit mix of the node address, modulo ten, and lookup of the five-bit node mask with three bits set.
`timescale 1ns / 1ps

module hbns_mask_sel (
  input  logic                clk,
  input  hbns_pkg::stage_en_t en,
  input  logic [31:0]         node_address,
  output logic [4:0]          mask
);

  logic [31:0] m1_r;
  logic [31:0] m2_r;
  logic [31:0] m3_r;
  logic [31:0] m4_r;
  logic [31:0] m5_r;
  logic [63:0] prod_r;
  logic [4:0]  mask_r;

  logic [31:0] m1_nxt;
  logic [31:0] m2_nxt;
  logic [31:0] m2x;
  logic [31:0] m3_nxt;
  logic [31:0] m4_nxt;
  logic [63:0] prod_nxt;
  logic [28:0] quo;
  logic [31:0] quo_x10;
  logic [31:0] rem_full;
  logic [4:0]  mask_nxt;

  assign m1_nxt   = node_address ^ (node_address >> 16);
  assign m2_nxt   = m1_r * hbns_pkg::MIX32_K;
  assign m2x      = m2_r ^ (m2_r >> 16);
  assign m3_nxt   = m2x * hbns_pkg::MIX32_K;
  assign m4_nxt   = m3_r ^ (m3_r >> 16);
  assign prod_nxt = m4_r * hbns_pkg::RECIP10;

  // remainder by ten through the reciprocal quotient
  assign quo      = prod_r[63:hbns_pkg::RECIP10_SHIFT];
  assign quo_x10  = 32'({quo, 3'b000}) + 32'({quo, 1'b0});
  assign rem_full = m5_r - quo_x10;
  assign mask_nxt = hbns_pkg::mask_lookup(rem_full[3:0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1_r <= m1_nxt;
    end
    if (en[1]) begin
      m2_r <= m2_nxt;
    end
    if (en[2]) begin
      m3_r <= m3_nxt;
    end
    if (en[3]) begin
      m4_r <= m4_nxt;
    end
    if (en[4]) begin
      m5_r   <= m4_r;
      prod_r <= prod_nxt;
    end
    if (en[5]) begin
      mask_r <= mask_nxt;
    end
  end

  assign mask = mask_r;

endmodule

[rtl/hashed_block_node_selector.sv]
// Top level of the hashed block node selector: config registers, pipeline control, output stage.
`timescale 1ns / 1ps

// Maps a storage block number to a destination node index. Each accepted beat
// is hashed as {node_address, block_number} through the splitmix64 finalizer,
// the hash is cut into one of three replica regions, and the region picks a set
// bit of a three-of-five node mask chosen by a 32-bit mix of node_address.
// The block is a seven-stage pipeline: one beat enters every cycle unless
// in_stall is high, and its result lands in the output register. The depth is set by
// the two 64-bit multiplications of the hash, each split into a partial-product
// stage and a sum stage. Stalls only hold stages that carry a beat, so bubbles
// are squeezed out and a new beat is taken while a result waits downstream.
// Status: 0 ok, 1 no nodes configured, 2 error (block number all ones, a node
// count other than 0, 1 or 5, or an all-ones hash). dest_index is 0 unless ok.
// node_address and node_count may be written only while the pipeline is empty.
module hashed_block_node_selector (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_block_number,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_dest_index,
  output logic [1:0]  out_status
);

  localparam int unsigned NS = hbns_pkg::PIPE_STAGES;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] node_address_r;
  logic [2:0]  node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r <= 32'd0;
      node_count_r   <= 3'd0;
    end else if (cfg_wr_en) begin
      case (hbns_pkg::cfg_index_t'(cfg_index))
        hbns_pkg::CFG_NODE_ADDRESS: node_address_r <= cfg_data;
        hbns_pkg::CFG_NODE_COUNT:   node_count_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or its successor moves.
  // Stage NS is the output register.
  // ---------------------------------------------------------------------------
  logic [NS-2:0]       valid_r;
  logic                out_valid_r;
  hbns_pkg::stage_en_t en;

  always_comb begin
    en[NS-1] = !out_valid_r || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NS - 1; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
      if (en[NS-1]) begin
        out_valid_r <= valid_r[NS-2];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Entry decision: special cases settle the status here; only a full ring
  // with a usable block number goes to the hash.
  // ---------------------------------------------------------------------------
  hbns_pkg::pre_dec_t pre_nxt;
  hbns_pkg::pre_dec_t pre_r [NS-1];

  always_comb begin
    pre_nxt.use_hash = 1'b0;
    pre_nxt.status   = hbns_pkg::ST_ERR;
    if (in_block_number == '1) begin
      pre_nxt.status = hbns_pkg::ST_ERR;
    end else if (node_count_r == hbns_pkg::NODE_COUNT_NONE) begin
      pre_nxt.status = hbns_pkg::ST_NONE;
    end else if (node_count_r == hbns_pkg::NODE_COUNT_ONE) begin
      pre_nxt.status = hbns_pkg::ST_OK;
    end else if (node_count_r == hbns_pkg::NODE_COUNT_FULL) begin
      pre_nxt.use_hash = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pre_r[0] <= pre_nxt;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        pre_r[k] <= pre_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hash and mask datapaths, both land at stage NS-1
  // ---------------------------------------------------------------------------
  logic [1:0] region;
  logic [4:0] mask;

  hbns_mix64 u_mix64 (
    .clk    (clk),
    .en     (en),
    .key    ({node_address_r, in_block_number}),
    .region (region)
  );

  hbns_mask_sel u_mask_sel (
    .clk          (clk),
    .en           (en),
    .node_address (node_address_r),
    .mask         (mask)
  );

  // ---------------------------------------------------------------------------
  // Output stage: resolve hashed beats; region 3 finds no set bit -> error
  // ---------------------------------------------------------------------------
  hbns_pkg::pick_t   pick;
  hbns_pkg::status_t status_nxt;
  logic [2:0]        dest_nxt;
  hbns_pkg::status_t status_r;
  logic [2:0]        dest_r;

  assign pick = hbns_pkg::pick_set_bit(mask, region);

  always_comb begin
    status_nxt = pre_r[NS-2].status;
    dest_nxt   = 3'd0;
    if (pre_r[NS-2].use_hash) begin
      if (pick.found) begin
        status_nxt = hbns_pkg::ST_OK;
        dest_nxt   = pick.idx;
      end else begin
        status_nxt = hbns_pkg::ST_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      status_r <= status_nxt;
      dest_r   <= dest_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_index = dest_r;
  assign out_status     = status_r;

endmodule
